FILE: hdl/tbsd_pkg.sv
// Package for the time bucket sensor decimator.
// Field widths, the reset bucket length and the command word passed from the
// front part to the back part. No dependencies.
`default_nettype none
package tbsd_pkg;

    localparam int W_TIME  = 48;
    localparam int W_VEC   = 48;
    localparam int W_TEMP  = 16;
    localparam int W_PRESS = 24;
    localparam int W_QUAT  = 32;
    localparam int W_LEN   = 32;
    localparam int W_EMIT  = 7;
    localparam int W_MEAN  = 24;

    localparam logic [W_LEN-1:0] LEN_RESET = 32'd10000;

    // One classified sample: its payload plus the bucket bookkeeping that the
    // front part has worked out for it.
    typedef struct packed {
        logic [W_TIME-1:0]        sample_time;
        logic [W_VEC-1:0]         accel;
        logic [W_VEC-1:0]         gyro;
        logic [W_VEC-1:0]         mag;
        logic signed [W_TEMP-1:0] temperature;
        logic [W_PRESS-1:0]       pressure;
        logic [2*W_QUAT-1:0]      orient;
        logic                     final_sample;
        logic [W_EMIT-1:0]        emit;
        logic                     gap;
        logic [W_TIME-1:0]        base;
        logic [W_LEN-1:0]         len;
        logic [W_TIME-1:0]        new_start;
    } t_cmd;

endpackage
`default_nettype wire

FILE: hdl/tbsd_smp_if.sv
// Sample channel interface: valid/ready handshake and one sample word.
// Uses tbsd_pkg for field widths.
`default_nettype none
interface tbsd_smp_if;
    logic                              valid;
    logic                              ready;
    logic [tbsd_pkg::W_TIME-1:0]       sample_time;
    logic [tbsd_pkg::W_VEC-1:0]        accel;
    logic [tbsd_pkg::W_VEC-1:0]        gyro;
    logic [tbsd_pkg::W_VEC-1:0]        mag;
    logic signed [tbsd_pkg::W_TEMP-1:0] temperature;
    logic [tbsd_pkg::W_PRESS-1:0]      pressure;
    logic [tbsd_pkg::W_QUAT-1:0]       orientation_wx;
    logic [tbsd_pkg::W_QUAT-1:0]       orientation_yz;
    logic                              final_sample;

    modport source (output valid, sample_time, accel, gyro, mag, temperature, pressure,
                    orientation_wx, orientation_yz, final_sample, input ready);
    modport sink   (input valid, sample_time, accel, gyro, mag, temperature, pressure,
                    orientation_wx, orientation_yz, final_sample, output ready);
endinterface
`default_nettype wire

FILE: hdl/tbsd_bkt_if.sv
// Bucket result channel interface: valid/ready handshake and one result word.
// Uses tbsd_pkg for field widths.
`default_nettype none
interface tbsd_bkt_if;
    logic                               valid;
    logic                               ready;
    logic [tbsd_pkg::W_TIME-1:0]        bucket_time;
    logic [tbsd_pkg::W_VEC-1:0]         accel_avg;
    logic [tbsd_pkg::W_VEC-1:0]         gyro_avg;
    logic [tbsd_pkg::W_VEC-1:0]         mag_avg;
    logic signed [tbsd_pkg::W_TEMP-1:0] temperature_avg;
    logic [tbsd_pkg::W_PRESS-1:0]       pressure_avg;
    logic [tbsd_pkg::W_QUAT-1:0]        orientation_out_wx;
    logic [tbsd_pkg::W_QUAT-1:0]        orientation_out_yz;
    logic                               last_of_run;
    logic                               recording_done;
    logic                               overflow_flag;

    modport source (output valid, bucket_time, accel_avg, gyro_avg, mag_avg, temperature_avg,
                    pressure_avg, orientation_out_wx, orientation_out_yz, last_of_run,
                    recording_done, overflow_flag, input ready);
    modport sink   (input valid, bucket_time, accel_avg, gyro_avg, mag_avg, temperature_avg,
                    pressure_avg, orientation_out_wx, orientation_out_yz, last_of_run,
                    recording_done, overflow_flag, output ready);
endinterface
`default_nettype wire

FILE: hdl/tbsd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned; standalone, no package dependency.
`default_nettype none
module tbsd_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [NW-1:0]      o_quot,
    output logic [DW-1:0]      o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic [DW+1:0] w_diff;

    assign w_sh   = {r_rem, r_quo[NW-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DW+1]) begin
                r_rem <= w_diff[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

FILE: hdl/tbsd_front.sv
// Front part: accepts a sample, divides its distance from the open bucket by
// the bucket length and hands a classified command to the queue.
// Uses tbsd_pkg, tbsd_smp_if and tbsd_div.
`default_nettype none
module tbsd_front #(
    parameter int MAX_GAP_RESULTS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [tbsd_pkg::W_LEN-1:0]    i_bucket_length,
    tbsd_smp_if.sink                           i_smp,
    input  wire logic                          i_q_full,
    output logic                               o_q_push,
    output tbsd_pkg::t_cmd                     o_q_cmd
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                      r_st;
    logic [tbsd_pkg::W_TIME-1:0]     r_bs;
    tbsd_pkg::t_cmd                  r_item;
    logic                            w_accept;
    logic [tbsd_pkg::W_LEN-1:0]      w_len;
    logic [tbsd_pkg::W_TIME-1:0]     w_dividend;
    logic                            w_done;
    logic [tbsd_pkg::W_TIME-1:0]     w_quot;
    logic [tbsd_pkg::W_LEN-1:0]      w_rem;
    logic                            w_gap;

    assign i_smp.ready = (r_st == F_IDLE);
    assign w_accept    = i_smp.valid && (r_st == F_IDLE);
    assign w_len       = (i_bucket_length == '0) ? tbsd_pkg::W_LEN'(1) : i_bucket_length;
    // A sample earlier than the open bucket stays in it.
    assign w_dividend  = (i_smp.sample_time >= r_bs) ? (i_smp.sample_time - r_bs) : '0;

    tbsd_div #(.NW(tbsd_pkg::W_TIME), .DW(tbsd_pkg::W_LEN)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (w_dividend),
        .i_divisor  (w_len),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_gap = (w_quot > tbsd_pkg::W_TIME'(MAX_GAP_RESULTS));

    always_comb begin
        o_q_cmd      = r_item;
        o_q_cmd.gap  = w_gap;
        o_q_cmd.emit = w_gap ? tbsd_pkg::W_EMIT'(MAX_GAP_RESULTS)
                             : w_quot[tbsd_pkg::W_EMIT-1:0];
        o_q_cmd.new_start = (w_quot != '0)
            ? (r_item.sample_time - {{(tbsd_pkg::W_TIME - tbsd_pkg::W_LEN){1'b0}}, w_rem})
            : r_item.base;
    end

    assign o_q_push = (r_st == F_PUSH) && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
            r_bs <= '0;
        end else begin
            case (r_st)
                F_IDLE: begin
                    if (w_accept) r_st <= F_DIV;
                end
                F_DIV: begin
                    if (w_done) r_st <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_st <= F_IDLE;
                        r_bs <= r_item.final_sample ? '0 : o_q_cmd.new_start;
                    end
                end
                default: r_st <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.sample_time  <= i_smp.sample_time;
            r_item.accel        <= i_smp.accel;
            r_item.gyro         <= i_smp.gyro;
            r_item.mag          <= i_smp.mag;
            r_item.temperature  <= i_smp.temperature;
            r_item.pressure     <= i_smp.pressure;
            r_item.orient       <= {i_smp.orientation_yz, i_smp.orientation_wx};
            r_item.final_sample <= i_smp.final_sample;
            r_item.emit         <= '0;
            r_item.gap          <= 1'b0;
            r_item.base         <= r_bs;
            r_item.len          <= w_len;
            r_item.new_start    <= r_bs;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/tbsd_queue.sv
// Two-entry command queue between the front and back parts.
// Uses tbsd_pkg for the command type.
`default_nettype none
module tbsd_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  tbsd_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    input  wire logic     i_pop,
    output tbsd_pkg::t_cmd o_data
);
    tbsd_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

FILE: hdl/tbsd_back.sv
// Back part: keeps the running sums of the open bucket, emits closed buckets
// with their means and chosen orientation, and folds each sample in.
// Uses tbsd_pkg, tbsd_bkt_if and tbsd_div.
`default_nettype none
module tbsd_back #(
    parameter int AXES            = 3,
    parameter int COUNT_WIDTH     = 16,
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  tbsd_pkg::t_cmd i_q_cmd,
    output logic        o_q_pop,
    tbsd_bkt_if.source  o_bkt
);
    localparam int NV  = 3 * AXES;
    localparam int NCH = NV + 2;
    localparam int KW  = $clog2(NCH);
    localparam int SW  = COMPONENT_WIDTH + COUNT_WIDTH;
    localparam int TW  = tbsd_pkg::W_TEMP + COUNT_WIDTH;
    localparam int PW  = tbsd_pkg::W_PRESS + COUNT_WIDTH;
    localparam int MW  = tbsd_pkg::W_MEAN;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOP   = 3'd1;
    localparam logic [2:0] S_DIV_GO = 3'd2;
    localparam logic [2:0] S_DIV_WT = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_ACC    = 3'd5;

    logic [2:0]                   r_st;
    tbsd_pkg::t_cmd               r_cmd;
    logic [tbsd_pkg::W_EMIT-1:0]  r_left;
    logic                         r_firstb;
    logic [tbsd_pkg::W_TIME-1:0]  r_bt;
    logic [KW-1:0]                r_k;

    logic signed [SW-1:0]         r_vsum [NV];
    logic signed [TW-1:0]         r_tsum;
    logic [PW-1:0]                r_psum;
    logic [COUNT_WIDTH-1:0]       r_cnt;
    logic                         r_sat;
    logic [tbsd_pkg::W_TIME-1:0]  r_prev_t;
    logic [2*tbsd_pkg::W_QUAT-1:0] r_prev_q;
    logic                         r_prev_v;
    logic [2*tbsd_pkg::W_QUAT-1:0] r_first_q;
    logic [2*tbsd_pkg::W_QUAT-1:0] r_chosen_q;
    logic                         r_found;
    logic [MW-1:0]                r_hm [NCH];

    logic                         r_ov;
    logic [tbsd_pkg::W_TIME-1:0]  r_o_time;
    logic [tbsd_pkg::W_VEC-1:0]   r_o_acc;
    logic [tbsd_pkg::W_VEC-1:0]   r_o_gyr;
    logic [tbsd_pkg::W_VEC-1:0]   r_o_mag;
    logic [tbsd_pkg::W_TEMP-1:0]  r_o_temp;
    logic [tbsd_pkg::W_PRESS-1:0] r_o_press;
    logic [2*tbsd_pkg::W_QUAT-1:0] r_o_q;
    logic                         r_o_last;
    logic                         r_o_done;
    logic                         r_o_ovf;

    logic                         w_out_free;
    logic                         w_load;
    logic [PW-1:0]                w_mag_in;
    logic                         w_neg;
    logic                         w_div_done;
    logic [PW-1:0]                w_quot;
    logic [COUNT_WIDTH-1:0]       w_rem;
    logic [MW-1:0]                w_mean;
    logic [tbsd_pkg::W_VEC-1:0]   w_acc_p;
    logic [tbsd_pkg::W_VEC-1:0]   w_gyr_p;
    logic [tbsd_pkg::W_VEC-1:0]   w_mag_p;
    logic [2*tbsd_pkg::W_QUAT-1:0] w_q;
    logic [tbsd_pkg::W_TIME:0]    w_c;
    logic [tbsd_pkg::W_TIME:0]    w_t;
    logic signed [tbsd_pkg::W_TIME+1:0] w_dp;
    logic signed [tbsd_pkg::W_TIME+1:0] w_dt;

    assign o_q_pop    = (r_st == S_IDLE) && i_q_valid;
    assign w_out_free = !r_ov || o_bkt.ready;
    assign w_load     = (r_st == S_EMIT) && w_out_free;

    // Magnitude and sign of the channel under division.
    always_comb begin
        logic signed [SW-1:0] v;
        v        = '0;
        w_mag_in = '0;
        w_neg    = 1'b0;
        for (int j = 0; j < NV; j++) begin
            if (r_k == KW'(j)) v = r_vsum[j];
        end
        if (r_k == KW'(NV)) begin
            w_neg    = r_tsum[TW-1];
            w_mag_in = PW'(w_neg ? (-r_tsum) : r_tsum);
        end else if (r_k == KW'(NV + 1)) begin
            w_mag_in = r_psum;
        end else begin
            w_neg    = v[SW-1];
            w_mag_in = PW'(w_neg ? (-v) : v);
        end
    end

    tbsd_div #(.NW(PW), .DW(COUNT_WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_st == S_DIV_GO),
        .i_dividend (w_mag_in),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // The remainder is not needed; the mean truncates toward zero.
    assign w_mean = (w_neg && (w_rem == w_rem)) ? (-w_quot[MW-1:0]) : w_quot[MW-1:0];

    always_comb begin
        w_acc_p = '0;
        w_gyr_p = '0;
        w_mag_p = '0;
        for (int a = 0; a < AXES; a++) begin
            w_acc_p[a*COMPONENT_WIDTH +: COMPONENT_WIDTH] =
                r_hm[KW'(a)][COMPONENT_WIDTH-1:0];
            w_gyr_p[a*COMPONENT_WIDTH +: COMPONENT_WIDTH] =
                r_hm[KW'(AXES + a)][COMPONENT_WIDTH-1:0];
            w_mag_p[a*COMPONENT_WIDTH +: COMPONENT_WIDTH] =
                r_hm[KW'(2*AXES + a)][COMPONENT_WIDTH-1:0];
        end
    end

    assign w_q = r_found ? r_chosen_q : ((r_cnt != '0) ? r_first_q : r_cmd.orient);

    // Centre of the bucket the sample lands in, and distances either side.
    assign w_c  = {1'b0, r_cmd.new_start} + {17'b0, r_cmd.len[tbsd_pkg::W_LEN-1:1]};
    assign w_t  = {1'b0, r_cmd.sample_time};
    assign w_dp = $signed({1'b0, w_c}) - $signed({2'b00, r_prev_t});
    assign w_dt = $signed({1'b0, w_t - w_c});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ov     <= 1'b0;
            r_left   <= '0;
            r_firstb <= 1'b0;
            r_k      <= '0;
            for (int j = 0; j < NV; j++) r_vsum[j] <= '0;
            r_tsum   <= '0;
            r_psum   <= '0;
            r_cnt    <= '0;
            r_sat    <= 1'b0;
            r_prev_t <= '0;
            r_prev_q <= '0;
            r_prev_v <= 1'b0;
            r_first_q  <= '0;
            r_chosen_q <= '0;
            r_found  <= 1'b0;
            for (int j = 0; j < NCH; j++) r_hm[j] <= '0;
        end else begin
            if (o_bkt.ready) r_ov <= 1'b0;
            if (w_load) r_ov <= 1'b1;
            case (r_st)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_left   <= i_q_cmd.emit;
                        r_firstb <= 1'b1;
                        r_st     <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    if (r_left == '0) begin
                        r_st <= S_ACC;
                    end else if (r_firstb && (r_cnt != '0)) begin
                        r_k  <= '0;
                        r_st <= S_DIV_GO;
                    end else begin
                        r_st <= S_EMIT;
                    end
                end
                S_DIV_GO: r_st <= S_DIV_WT;
                S_DIV_WT: begin
                    if (w_div_done) begin
                        r_hm[r_k] <= w_mean;
                        if (r_k == KW'(NCH - 1)) begin
                            r_st <= S_EMIT;
                        end else begin
                            r_k  <= r_k + 1'b1;
                            r_st <= S_DIV_GO;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        for (int j = 0; j < NV; j++) r_vsum[j] <= '0;
                        r_tsum     <= '0;
                        r_psum     <= '0;
                        r_cnt      <= '0;
                        r_sat      <= 1'b0;
                        r_first_q  <= '0;
                        r_chosen_q <= '0;
                        r_found    <= 1'b0;
                        r_left     <= r_left - 1'b1;
                        r_firstb   <= 1'b0;
                        r_st       <= S_LOOP;
                    end
                end
                S_ACC: begin
                    r_st <= S_IDLE;
                    if (r_cmd.final_sample) begin
                        for (int j = 0; j < NV; j++) r_vsum[j] <= '0;
                        r_tsum     <= '0;
                        r_psum     <= '0;
                        r_cnt      <= '0;
                        r_sat      <= 1'b0;
                        r_prev_t   <= '0;
                        r_prev_q   <= '0;
                        r_prev_v   <= 1'b0;
                        r_first_q  <= '0;
                        r_chosen_q <= '0;
                        r_found    <= 1'b0;
                        for (int j = 0; j < NCH; j++) r_hm[j] <= '0;
                    end else begin
                        if (!r_found && (w_t >= w_c)) begin
                            r_chosen_q <= (r_prev_v && (w_dp < w_dt)) ? r_prev_q
                                                                      : r_cmd.orient;
                            r_found    <= 1'b1;
                        end
                        if (r_cnt == COUNT_MAX) begin
                            r_sat <= 1'b1;
                        end else begin
                            if (r_cnt == '0) r_first_q <= r_cmd.orient;
                            for (int a = 0; a < AXES; a++) begin
                                r_vsum[a] <= r_vsum[a] + SW'($signed(
                                    r_cmd.accel[a*COMPONENT_WIDTH +: COMPONENT_WIDTH]));
                                r_vsum[AXES + a] <= r_vsum[AXES + a] + SW'($signed(
                                    r_cmd.gyro[a*COMPONENT_WIDTH +: COMPONENT_WIDTH]));
                                r_vsum[2*AXES + a] <= r_vsum[2*AXES + a] + SW'($signed(
                                    r_cmd.mag[a*COMPONENT_WIDTH +: COMPONENT_WIDTH]));
                            end
                            r_tsum <= r_tsum + TW'(r_cmd.temperature);
                            r_psum <= r_psum + PW'(r_cmd.pressure);
                            r_cnt  <= r_cnt + 1'b1;
                        end
                        r_prev_t <= r_cmd.sample_time;
                        r_prev_q <= r_cmd.orient;
                        r_prev_v <= 1'b1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            r_bt  <= i_q_cmd.base + {17'b0, i_q_cmd.len[tbsd_pkg::W_LEN-1:1]};
        end else if (w_load) begin
            r_bt <= r_bt + {16'b0, r_cmd.len};
        end
        if (w_load) begin
            r_o_time  <= r_bt;
            r_o_acc   <= w_acc_p;
            r_o_gyr   <= w_gyr_p;
            r_o_mag   <= w_mag_p;
            r_o_temp  <= r_hm[KW'(NV)][tbsd_pkg::W_TEMP-1:0];
            r_o_press <= r_hm[KW'(NV + 1)][tbsd_pkg::W_PRESS-1:0];
            r_o_q     <= w_q;
            r_o_last  <= (r_left == tbsd_pkg::W_EMIT'(1));
            r_o_done  <= (r_left == tbsd_pkg::W_EMIT'(1)) && r_cmd.final_sample;
            r_o_ovf   <= r_sat || r_cmd.gap;
        end
    end

    assign o_bkt.valid              = r_ov;
    assign o_bkt.bucket_time        = r_o_time;
    assign o_bkt.accel_avg          = r_o_acc;
    assign o_bkt.gyro_avg           = r_o_gyr;
    assign o_bkt.mag_avg            = r_o_mag;
    assign o_bkt.temperature_avg    = $signed(r_o_temp);
    assign o_bkt.pressure_avg       = r_o_press;
    assign o_bkt.orientation_out_wx = r_o_q[tbsd_pkg::W_QUAT-1:0];
    assign o_bkt.orientation_out_yz = r_o_q[2*tbsd_pkg::W_QUAT-1:tbsd_pkg::W_QUAT];
    assign o_bkt.last_of_run        = r_o_last;
    assign o_bkt.recording_done     = r_o_done;
    assign o_bkt.overflow_flag      = r_o_ovf;
endmodule
`default_nettype wire

FILE: hdl/time_bucket_sensor_decimator.sv
// Time bucket sensor decimator, top level.
// Holds the bucket length register and joins front, queue and back parts.
// Uses tbsd_pkg, tbsd_smp_if, tbsd_bkt_if, tbsd_front, tbsd_queue, tbsd_back.
//
// Samples come in on i_smp in nondecreasing time order; each closed bucket
// leaves on o_bkt as one word carrying the truncated means, the chosen
// orientation and run flags. The front part takes a sample and runs a
// bit-serial division of its distance from the open bucket by the
// bucket length; it accepts the next sample as soon as the command is queued.
// The back part folds each sample in, emits each bucket that closes, and
// works out the 3*AXES+2 means when a bucket with samples closes, since
// every mean goes through one shared serial divider. A queue of two
// commands lets both parts stall separately.
`default_nettype none
module time_bucket_sensor_decimator #(
    parameter int AXES            = 3,
    parameter int COUNT_WIDTH     = 16,
    parameter int MAX_GAP_RESULTS = 64,
    parameter int COMPONENT_WIDTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [tbsd_pkg::W_LEN-1:0] i_cfg_wdata,
    tbsd_smp_if.sink                        i_smp,
    tbsd_bkt_if.source                      o_bkt
);
    logic [tbsd_pkg::W_LEN-1:0] r_bucket_length;
    logic                       w_push;
    logic                       w_pop;
    logic                       w_full;
    logic                       w_qvalid;
    tbsd_pkg::t_cmd             w_cmd_in;
    tbsd_pkg::t_cmd             w_cmd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_length <= tbsd_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_bucket_length <= i_cfg_wdata;
        end
    end

    tbsd_front #(.MAX_GAP_RESULTS(MAX_GAP_RESULTS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_bucket_length (r_bucket_length),
        .i_smp           (i_smp),
        .i_q_full        (w_full),
        .o_q_push        (w_push),
        .o_q_cmd         (w_cmd_in)
    );

    tbsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out)
    );

    tbsd_back #(
        .AXES            (AXES),
        .COUNT_WIDTH     (COUNT_WIDTH),
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qvalid),
        .i_q_cmd   (w_cmd_out),
        .o_q_pop   (w_pop),
        .o_bkt     (o_bkt)
    );

    // A word that closes a recording is always the last of its run.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bkt.valid && o_bkt.recording_done |-> o_bkt.last_of_run)
        else $error("recording_done without last_of_run");

    // The back part never takes a command from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid)
        else $error("queue popped while empty");

    // The front part never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue pushed while full");
endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench for the time bucket sensor decimator.
// Drives timestamped samples through i_smp, predicts every bucket word and checks o_bkt.
// Depends on tbsd_pkg, tbsd_smp_if, tbsd_bkt_if and time_bucket_sensor_decimator.
`timescale 1ns / 1ps
module testbench;

    localparam int AXES_N   = 3;
    localparam int CNT_MAX  = 65535;
    localparam int GAP_MAX  = 64;

    typedef struct packed {
        logic [47:0] bucket_time;
        logic [47:0] accel_avg;
        logic [47:0] gyro_avg;
        logic [47:0] mag_avg;
        logic [15:0] temperature_avg;
        logic [23:0] pressure_avg;
        logic [31:0] orient_wx;
        logic [31:0] orient_yz;
        logic        last_of_run;
        logic        recording_done;
        logic        overflow_flag;
    } t_bucket;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [31:0] i_cfg_wdata;
    tbsd_smp_if smp ();
    tbsd_bkt_if bkt ();

    time_bucket_sensor_decimator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_smp(smp.sink), .o_bkt(bkt.source)
    );

    // Predictor state.
    logic [31:0] p_len;
    logic [47:0] p_start;
    longint      p_acc [3];
    longint      p_gyr [3];
    longint      p_mag [3];
    longint      p_temp;
    longint      p_press;
    int          p_count;
    bit          p_sat;
    logic [47:0] p_prev_time;
    logic [63:0] p_prev_orient;
    bit          p_prev_valid;
    logic [63:0] p_first_orient;
    logic [63:0] p_chosen;
    bit          p_found;
    logic [63:0] p_held [4];

    t_bucket expected_buckets[$];
    int      errors = 0;
    logic [47:0] now_time;
    bit      hold_off = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint comp(logic [47:0] v, int a);
        logic signed [15:0] c;
        c = v[a*16 +: 16];
        return longint'(c);
    endfunction

    function automatic logic [47:0] pack_mean(longint s0, longint s1, longint s2, int n);
        logic [47:0] r;
        longint q0, q1, q2;
        q0 = s0 / n;
        q1 = s1 / n;
        q2 = s2 / n;
        r = {q2[15:0], q1[15:0], q0[15:0]};
        return r;
    endfunction

    task automatic clear_bucket();
        for (int a = 0; a < 3; a++) begin
            p_acc[a] = 0;
            p_gyr[a] = 0;
            p_mag[a] = 0;
        end
        p_temp = 0;
        p_press = 0;
        p_count = 0;
        p_sat = 0;
        p_first_orient = 0;
        p_chosen = 0;
        p_found = 0;
    endtask

    task automatic reset_recording();
        p_start = 0;
        clear_bucket();
        p_prev_time = 0;
        p_prev_orient = 0;
        p_prev_valid = 0;
        for (int i = 0; i < 4; i++) p_held[i] = 0;
    endtask

    task automatic close_bucket(logic [63:0] len, logic [63:0] closing, bit gap,
                                ref t_bucket b);
        logic [63:0] q;
        longint tq, pq;
        logic [63:0] bt;
        if (p_count > 0) begin
            tq = p_temp / p_count;
            pq = p_press / p_count;
            p_held[0] = pack_mean(p_acc[0], p_acc[1], p_acc[2], p_count);
            p_held[1] = pack_mean(p_gyr[0], p_gyr[1], p_gyr[2], p_count);
            p_held[2] = pack_mean(p_mag[0], p_mag[1], p_mag[2], p_count);
            p_held[3] = {24'd0, pq[23:0], tq[15:0]};
        end
        if (p_found) q = p_chosen;
        else if (p_count > 0) q = p_first_orient;
        else q = closing;
        bt = {16'd0, p_start} + len / 2;
        b.bucket_time = bt[47:0];
        b.accel_avg = p_held[0][47:0];
        b.gyro_avg = p_held[1][47:0];
        b.mag_avg = p_held[2][47:0];
        b.temperature_avg = p_held[3][15:0];
        b.pressure_avg = p_held[3][39:16];
        b.orient_wx = q[31:0];
        b.orient_yz = q[63:32];
        b.last_of_run = 0;
        b.recording_done = 0;
        b.overflow_flag = p_sat || gap;
        clear_bucket();
    endtask

    // Works out the bucket words that one sample releases and queues them.
    task automatic predict_sample(logic [47:0] t, logic [47:0] ac, logic [47:0] gy,
                                  logic [47:0] mg, logic [15:0] tp, logic [23:0] pr,
                                  logic [63:0] orient, bit fin);
        logic [63:0] len, n, emit, base, c;
        longint dp, dt;
        bit gap;
        t_bucket b;
        t_bucket outs[$];
        len = (p_len == 0) ? 64'd1 : {32'd0, p_len};
        n = (t >= p_start) ? ({16'd0, t} - {16'd0, p_start}) / len : 0;
        gap = n > GAP_MAX;
        emit = gap ? GAP_MAX : n;
        base = {16'd0, p_start};
        for (int e = 0; e < emit; e++) begin
            close_bucket(len, orient, gap, b);
            outs.push_back(b);
            p_start = p_start + len[47:0];
        end
        if (n > 0) begin
            c = base + n * len;
            p_start = c[47:0];
            clear_bucket();
        end
        if (!fin) begin
            c = {16'd0, p_start} + len / 2;
            if (!p_found && {16'd0, t} >= c) begin
                dp = longint'(c) - longint'({16'd0, p_prev_time});
                dt = longint'({16'd0, t} - c);
                p_chosen = (p_prev_valid && dp < dt) ? p_prev_orient : orient;
                p_found = 1;
            end
            if (p_count >= CNT_MAX) begin
                p_sat = 1;
            end else begin
                if (p_count == 0) p_first_orient = orient;
                for (int a = 0; a < AXES_N; a++) begin
                    p_acc[a] += comp(ac, a);
                    p_gyr[a] += comp(gy, a);
                    p_mag[a] += comp(mg, a);
                end
                p_temp += longint'($signed(tp));
                p_press += longint'(pr);
                p_count++;
            end
            p_prev_time = t;
            p_prev_orient = orient;
            p_prev_valid = 1;
        end
        if (outs.size() > 0) begin
            outs[outs.size()-1].last_of_run = 1;
            if (fin) outs[outs.size()-1].recording_done = 1;
        end
        foreach (outs[i]) expected_buckets.push_back(outs[i]);
        if (fin) reset_recording();
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Sender: bursts of random length; valid stays high within a burst and drops
    // only for the random gap before the next one.
    int burst_left = 0;

    task automatic send_sample(logic [47:0] t, logic [47:0] ac, logic [47:0] gy,
                               logic [47:0] mg, logic [15:0] tp, logic [23:0] pr,
                               logic [63:0] orient, bit fin);
        int gap_len;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_len = $urandom_range(0, 6);
            if (gap_len > 0) begin
                smp.valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
        burst_left--;
        smp.valid <= 1'b1;
        smp.sample_time <= t;
        smp.accel <= ac;
        smp.gyro <= gy;
        smp.mag <= mg;
        smp.temperature <= tp;
        smp.pressure <= pr;
        smp.orientation_wx <= orient[31:0];
        smp.orientation_yz <= orient[63:32];
        smp.final_sample <= fin;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        predict_sample(t, ac, gy, mg, tp, pr, orient, fin);
    endtask

    function automatic logic [47:0] rvec();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic send_random(logic [47:0] t, bit fin);
        send_sample(t, rvec(), rvec(), rvec(), 16'($urandom()), 24'($urandom()),
                    {$urandom(), $urandom()}, fin);
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        burst_left = 0;
        while (expected_buckets.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic write_length(logic [31:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        p_len = v;
    endtask

    // Receiver: stalls on its own pattern; a long hold-off when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) bkt.ready <= 1'b0;
        else bkt.ready <= ($urandom_range(0, 3) != 0) || ((now_time / 256) % 3 == 0);
    end

    always @(posedge i_clk) begin
        t_bucket w;
        if (i_rst_n && bkt.valid && bkt.ready) begin
            if (expected_buckets.size() == 0) begin
                report("unexpected word", bkt.bucket_time, 0);
            end else begin
                w = expected_buckets.pop_front();
                if (bkt.bucket_time !== w.bucket_time)
                    report("bucket_time", bkt.bucket_time, w.bucket_time);
                if (bkt.accel_avg !== w.accel_avg) report("accel_avg", bkt.accel_avg, w.accel_avg);
                if (bkt.gyro_avg !== w.gyro_avg) report("gyro_avg", bkt.gyro_avg, w.gyro_avg);
                if (bkt.mag_avg !== w.mag_avg) report("mag_avg", bkt.mag_avg, w.mag_avg);
                if (bkt.temperature_avg !== w.temperature_avg)
                    report("temperature_avg", bkt.temperature_avg, w.temperature_avg);
                if (bkt.pressure_avg !== w.pressure_avg)
                    report("pressure_avg", bkt.pressure_avg, w.pressure_avg);
                if (bkt.orientation_out_wx !== w.orient_wx)
                    report("orientation_out_wx", bkt.orientation_out_wx, w.orient_wx);
                if (bkt.orientation_out_yz !== w.orient_yz)
                    report("orientation_out_yz", bkt.orientation_out_yz, w.orient_yz);
                if (bkt.last_of_run !== w.last_of_run)
                    report("last_of_run", bkt.last_of_run, w.last_of_run);
                if (bkt.recording_done !== w.recording_done)
                    report("recording_done", bkt.recording_done, w.recording_done);
                if (bkt.overflow_flag !== w.overflow_flag)
                    report("overflow_flag", bkt.overflow_flag, w.overflow_flag);
            end
        end
    end

    // Extremes of every field, a gap beyond the limit, a backwards step and a final sample.
    task automatic test_directed();
        send_sample(48'd0, 48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'hffff_0001_ffff,
                    16'h7fff, 24'hffffff, 64'hffff_ffff_ffff_ffff, 0);
        send_sample(48'd3, 48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h0, 16'h8000, 24'h0,
                    64'h0, 0);
        send_sample(48'd9, 48'hffff_ffff_ffff, 48'h1, 48'h8001_7ffe_0003, 16'hffff, 24'd7,
                    64'h1234_5678_9abc_def0, 0);
        send_sample(48'd5, rvec(), rvec(), rvec(), 16'd5, 24'd9, 64'h55, 0);
        send_sample(48'd10, rvec(), rvec(), rvec(), 16'd1, 24'd1, 64'h66, 0);
        send_sample(48'd16, rvec(), rvec(), rvec(), 16'd2, 24'd2, 64'h77, 0);
        send_sample(48'd24, rvec(), rvec(), rvec(), 16'd2, 24'd2, 64'h88, 0);
        send_sample(48'd55, rvec(), rvec(), rvec(), 16'd3, 24'd3, 64'h99, 0);
        send_sample(48'd1500, rvec(), rvec(), rvec(), 16'd3, 24'd3, 64'haa, 0);
        send_sample(48'hffff_ffff_fff0, rvec(), rvec(), rvec(), 16'd4, 24'd4, 64'hbb, 0);
        send_sample(48'hffff_ffff_ffff, rvec(), rvec(), rvec(), 16'd4, 24'd4, 64'hcc, 1);
        send_random(48'd37, 1);
    endtask

    // Recordings with random content, random time steps and an occasional longer jump.
    task automatic test_recordings(int count);
        logic [47:0] t;
        int left;
        t = 0;
        left = count;
        while (left > 0) begin
            t = t + 48'($urandom_range(0, (p_len < 4096) ? 3 * p_len : 30000));
            if ($urandom_range(0, 30) == 0) t = t + 48'($urandom_range(0, 2000));
            left--;
            send_random(t, (left % 40 == 0) || ($urandom_range(0, 60) == 0));
            if (left % 40 == 0) t = 48'($urandom_range(0, 20));
        end
    endtask

    // The receiver holds off while samples keep coming, then the sender waits for all words.
    task automatic test_back_pressure();
        hold_off = 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            test_recordings(12);
        join
        drain();
        test_recordings(6);
    endtask

    initial begin
        now_time = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 0;
        smp.valid = 1'b0;
        smp.sample_time = 0;
        smp.accel = 0;
        smp.gyro = 0;
        smp.mag = 0;
        smp.temperature = 0;
        smp.pressure = 0;
        smp.orientation_wx = 0;
        smp.orientation_yz = 0;
        smp.final_sample = 0;
        bkt.ready = 1'b0;
        p_len = tbsd_pkg::LEN_RESET;
        reset_recording();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_recordings(20);
        write_length(32'd1);
        test_directed();
        write_length(32'd0);
        test_recordings(20);
        write_length(32'd7);
        test_recordings(90);
        test_back_pressure();
        write_length(32'hffff_ffff);
        test_recordings(10);
        send_random(48'hffff_ffff_ffff, 1);
        write_length(32'd1000);
        test_recordings(100);
        send_random(48'hffff_ffff_ffff, 1);
        drain();
        if (errors == 0) begin
            $display("PASS time_bucket_sensor_decimator");
        end else begin
            $display("FAIL time_bucket_sensor_decimator");
        end
        $finish;
    end

    always @(posedge i_clk) now_time <= now_time + 1;

    initial begin
        #4000000;
        $display("FAIL time_bucket_sensor_decimator");
        $finish;
    end
endmodule
